/* sv/rmth_pkg.sv */
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median unit
// Sizes of the two sorted cell chains, the cell command codes, the control
// bundle that drives one chain, and the controller states.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int unsigned HEAP_DEPTH = 512;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [DATA_W-1:0]  value;
    } t_chain_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLACE,
        ST_BALANCE,
        ST_FINISH
    } t_state;

endpackage

/* sv/running_median_two_heaps_unit.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit: running median over two sorted cell chains
// The result is registered in finish, which follows place and balance.
// A new sample is taken only in idle, after the last has passed place, balance
// (skipped on overflow) and finish; a stalled output holds a due result in finish.
// Each chain step (insert or pop) updates all cells at once.
// Reset clears both counts and the controller; cell contents stay undefined.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_restart,
    input  logic signed [rmth_pkg::DATA_W-1:0] i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [rmth_pkg::DATA_W-1:0] o_median,
    output logic                               o_overflow
);
    import rmth_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [DATA_W-1:0] r_sample;
    logic [CNT_W-1:0]  r_lo_cnt;
    logic [CNT_W-1:0]  n_lo_cnt;
    logic [CNT_W-1:0]  r_up_cnt;
    logic [CNT_W-1:0]  n_up_cnt;
    logic              r_ovf;
    logic              n_ovf;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_median;
    logic              r_overflow;

    t_chain_ctl        lo_ctl;
    t_chain_ctl        up_ctl;
    logic [DATA_W-1:0] lo_top;
    logic [DATA_W-1:0] up_top;

    logic              in_accept;
    logic              to_lower;
    logic              full;
    logic              lo_heavy;
    logic              up_heavy;
    logic              need_res;
    logic              out_free;
    logic              load_out;

    rmth_chain u_lower (
        .i_clk   (i_clk),
        .i_is_max(1'b1),
        .i_ctl   (lo_ctl),
        .i_count (r_lo_cnt),
        .o_top   (lo_top)
    );

    rmth_chain u_upper (
        .i_clk   (i_clk),
        .i_is_max(1'b0),
        .i_ctl   (up_ctl),
        .i_count (r_up_cnt),
        .o_top   (up_top)
    );

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // Ties go to the upper half.
    assign to_lower = (r_lo_cnt == '0) || ($signed(lo_top) > $signed(r_sample));
    assign full     = to_lower ? (r_lo_cnt == CNT_W'(HEAP_DEPTH))
                               : (r_up_cnt == CNT_W'(HEAP_DEPTH));
    assign lo_heavy = {1'b0, r_lo_cnt} > ({1'b0, r_up_cnt} + (CNT_W+1)'(1));
    assign up_heavy = r_up_cnt > r_lo_cnt;
    assign need_res = r_ovf || (r_lo_cnt[0] ^ r_up_cnt[0]);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_state)
            ST_IDLE:    n_state = i_in_valid ? ST_PLACE : ST_IDLE;
            ST_PLACE:   n_state = full ? ST_FINISH : ST_BALANCE;
            ST_BALANCE: n_state = ST_FINISH;
            ST_FINISH:  n_state = (!need_res || out_free) ? ST_IDLE : ST_FINISH;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        lo_ctl   = '{op: CELL_HOLD, value: r_sample};
        up_ctl   = '{op: CELL_HOLD, value: r_sample};
        n_lo_cnt = r_lo_cnt;
        n_up_cnt = r_up_cnt;
        n_ovf    = r_ovf;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_ovf = 1'b0;
                if (in_accept && i_restart) begin
                    n_lo_cnt = '0;
                    n_up_cnt = '0;
                end
            end
            ST_PLACE: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else if (to_lower) begin
                    lo_ctl.op = CELL_INSERT;
                    n_lo_cnt  = r_lo_cnt + CNT_W'(1);
                end else begin
                    up_ctl.op = CELL_INSERT;
                    n_up_cnt  = r_up_cnt + CNT_W'(1);
                end
            end
            ST_BALANCE: begin
                // Move one top across so the lower half holds as many items
                // as the upper half, or one more.
                if (lo_heavy) begin
                    lo_ctl.op    = CELL_POP;
                    up_ctl.op    = CELL_INSERT;
                    up_ctl.value = lo_top;
                    n_lo_cnt     = r_lo_cnt - CNT_W'(1);
                    n_up_cnt     = r_up_cnt + CNT_W'(1);
                end else if (up_heavy) begin
                    up_ctl.op    = CELL_POP;
                    lo_ctl.op    = CELL_INSERT;
                    lo_ctl.value = up_top;
                    n_up_cnt     = r_up_cnt - CNT_W'(1);
                    n_lo_cnt     = r_lo_cnt + CNT_W'(1);
                end
            end
            ST_FINISH: begin
                load_out = need_res && out_free;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lo_cnt    <= '0;
            r_up_cnt    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lo_cnt <= n_lo_cnt;
            r_up_cnt <= n_up_cnt;
            r_ovf    <= n_ovf;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
        end
        if (load_out) begin
            r_median   <= (r_lo_cnt != '0) ? lo_top : '0;
            r_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;
    assign o_overflow  = r_overflow;

endmodule

/* sv/rmth_cell.sv */
// ----------------------------------------------------------------------------
// rmth_cell: one slot of a sorted chain
// Holds one sample. On an insert it keeps its value, takes the new value or
// takes its left neighbor's value; on a pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module rmth_cell (
    input  logic                       i_clk,
    input  rmth_pkg::t_chain_ctl       i_ctl,
    input  logic                       i_is_max,
    input  logic                       i_occ,
    input  logic [rmth_pkg::DATA_W-1:0] i_left_val,
    input  logic                       i_left_keep,
    input  logic [rmth_pkg::DATA_W-1:0] i_right_val,
    output logic [rmth_pkg::DATA_W-1:0] o_val,
    output logic                       o_keep
);
    import rmth_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              ranks_first;

    // A held value stays ahead of the new one if it ranks strictly above it.
    assign ranks_first = i_is_max ? ($signed(r_val) > $signed(i_ctl.value))
                                  : ($signed(r_val) < $signed(i_ctl.value));
    assign o_keep = i_occ && ranks_first;
    assign o_val  = r_val;

    always_comb begin
        case (i_ctl.op)
            CELL_INSERT: begin
                if (o_keep) begin
                    n_val = r_val;
                end else if (i_left_keep) begin
                    n_val = i_ctl.value;
                end else begin
                    n_val = i_left_val;
                end
            end
            CELL_POP: begin
                n_val = i_right_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* sv/rmth_chain.sv */
// ----------------------------------------------------------------------------
// rmth_chain: one heap kept as a sorted row of cells
// Cell 0 holds the top (largest for the lower half, smallest for the upper
// half). Insert and pop each update all cells at once.
// ----------------------------------------------------------------------------
module rmth_chain (
    input  logic                        i_clk,
    input  logic                        i_is_max,
    input  rmth_pkg::t_chain_ctl        i_ctl,
    input  logic [rmth_pkg::CNT_W-1:0]  i_count,
    output logic [rmth_pkg::DATA_W-1:0] o_top
);
    import rmth_pkg::*;

    logic [DATA_W-1:0] cell_val  [HEAP_DEPTH];
    logic              cell_keep [HEAP_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < HEAP_DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] left_val;
            logic              left_keep;
            logic [DATA_W-1:0] right_val;
            logic              occ;

            // Cell 0 has nothing ahead of it, so it takes the new value
            // whenever it does not keep its own.
            if (gi == 0) begin : g_head
                assign left_val  = i_ctl.value;
                assign left_keep = 1'b1;
            end else begin : g_body
                assign left_val  = cell_val[gi-1];
                assign left_keep = cell_keep[gi-1];
            end

            if (gi == HEAP_DEPTH - 1) begin : g_tail
                assign right_val = cell_val[gi];
            end else begin : g_inner
                assign right_val = cell_val[gi+1];
            end

            assign occ = (i_count > CNT_W'(gi));

            rmth_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (i_ctl),
                .i_is_max    (i_is_max),
                .i_occ       (occ),
                .i_left_val  (left_val),
                .i_left_keep (left_keep),
                .i_right_val (right_val),
                .o_val       (cell_val[gi]),
                .o_keep      (cell_keep[gi])
            );
        end
    endgenerate

    assign o_top = cell_val[0];

endmodule

/* verif/running_median_two_heaps_unit_tb.sv */
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit_tb: self-checking bench for the running median
// A short table of hand-picked samples (extremes, ties, restarts) comes first.
// It is followed by a long run that fills both halves to capacity and forces
// dropped samples, and then by many short restarted sequences of random
// values. A sorted-queue model of the two halves predicts every median not
// typed in the table. Both handshakes idle at random, and the output side
// holds off once for a long stretch so that the unit backs up into its input.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit_tb;

    typedef logic signed [rmth_pkg::DATA_W-1:0] t_sample;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_SILENT,
        CHK_MEDIAN
    } t_row_chk;

    typedef struct {
        bit       restart;
        t_sample  value;
        t_row_chk chk;
        t_sample  median;
    } t_row;

    typedef struct {
        t_sample median;
        bit      overflow;
    } t_median_result;

    localparam t_sample S_MIN = 32'sh8000_0000;
    localparam t_sample S_MAX = 32'sh7FFF_FFFF;
    localparam int unsigned SAMPLE_GOAL = 1400;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    i_restart   = 1'b0;
    t_sample i_sample    = '0;
    logic    i_out_stall = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_median;
    logic    o_overflow;

    // Lower half is kept ascending with its top at the back; upper half is
    // kept ascending with its top at the front.
    t_sample        low_half[$];
    t_sample        high_half[$];
    t_median_result pending_medians[$];

    int unsigned errors          = 0;
    int unsigned samples_sent    = 0;
    int unsigned restarts_sent   = 0;
    int unsigned results_seen    = 0;
    int unsigned overflows_seen  = 0;
    int unsigned gap_pct         = 30;
    int unsigned stall_pct       = 30;
    int unsigned hold_left       = 0;
    bit          long_hold_done  = 1'b0;

    t_row script [22] = '{
        '{1'b1, 32'sd0,       CHK_MEDIAN,  32'sd0},
        '{1'b0, S_MAX,        CHK_SILENT,  32'sd0},
        '{1'b0, S_MIN,        CHK_MEDIAN,  32'sd0},
        '{1'b0, S_MIN,        CHK_SILENT,  32'sd0},
        '{1'b0, S_MIN,        CHK_MEDIAN,  S_MIN},
        '{1'b1, S_MIN,        CHK_MEDIAN,  S_MIN},
        '{1'b1, S_MAX,        CHK_MEDIAN,  S_MAX},
        '{1'b0, S_MAX,        CHK_SILENT,  32'sd0},
        '{1'b0, S_MAX,        CHK_MEDIAN,  S_MAX},
        '{1'b1, 32'sd5,       CHK_MEDIAN,  32'sd5},
        '{1'b0, 32'sd5,       CHK_SILENT,  32'sd0},
        '{1'b0, 32'sd5,       CHK_MEDIAN,  32'sd5},
        '{1'b1, -32'sd1,      CHK_MEDIAN,  -32'sd1},
        '{1'b0, 32'sd1,       CHK_SILENT,  32'sd0},
        '{1'b0, 32'sd0,       CHK_MEDIAN,  32'sd0},
        '{1'b0, 32'sd100,     CHK_PREDICT, 32'sd0},
        '{1'b0, 32'sd90,      CHK_PREDICT, 32'sd0},
        '{1'b0, 32'sd80,      CHK_PREDICT, 32'sd0},
        '{1'b1, 32'sd10,      CHK_PREDICT, 32'sd0},
        '{1'b0, 32'sd20,      CHK_PREDICT, 32'sd0},
        '{1'b0, 32'sh1234_5678, CHK_PREDICT, 32'sd0},
        '{1'b0, 32'shEDCB_A988, CHK_PREDICT, 32'sd0}
    };

    running_median_two_heaps_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median),
        .o_overflow  (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic void insert_sorted(input bit into_low, input t_sample v);
        int k;
        k = 0;
        if (into_low) begin
            while (k < low_half.size() && low_half[k] <= v) k++;
            low_half.insert(k, v);
        end else begin
            while (k < high_half.size() && high_half[k] <= v) k++;
            high_half.insert(k, v);
        end
    endfunction

    // Updates both halves for one sample and reports the result it causes.
    function automatic void median_predict(input bit restart, input t_sample s,
                                           output bit produces, output t_sample med,
                                           output bit ovf);
        bit      to_low;
        t_sample moved;
        produces = 1'b0;
        med      = '0;
        ovf      = 1'b0;
        if (restart) begin
            low_half.delete();
            high_half.delete();
        end
        to_low = (low_half.size() == 0) || (low_half[$] > s);
        if ((to_low ? low_half.size() : high_half.size()) >= rmth_pkg::HEAP_DEPTH) begin
            // The sample is dropped and the halves are left as they were.
            produces = 1'b1;
            ovf      = 1'b1;
            med      = (low_half.size() > 0) ? low_half[$] : '0;
            return;
        end
        insert_sorted(to_low, s);
        if (low_half.size() > high_half.size() + 1) begin
            moved = low_half.pop_back();
            insert_sorted(1'b0, moved);
        end else if (high_half.size() > low_half.size()) begin
            moved = high_half.pop_front();
            insert_sorted(1'b1, moved);
        end
        if (((low_half.size() + high_half.size()) % 2) == 1) begin
            produces = 1'b1;
            med      = low_half[$];
        end
    endfunction

    function automatic int unsigned idle_length(input int unsigned pct);
        int unsigned r;
        if ($urandom_range(0, 99) >= pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return t_sample'($urandom_range(0, 16)) - 32'sd8;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 15;
            2: return 40;
            default: return 70;
        endcase
    endfunction

    task automatic send_sample(input bit restart, input t_sample value,
                               input t_row_chk chk, input t_sample typed_median);
        bit          produces;
        t_sample     med;
        bit          ovf;
        int unsigned gap;
        median_predict(restart, value, produces, med, ovf);
        case (chk)
            CHK_PREDICT: if (produces) pending_medians.push_back('{med, ovf});
            CHK_MEDIAN:  pending_medians.push_back('{typed_median, 1'b0});
            default: ;
        endcase
        gap = idle_length(gap_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        i_sample   <= value;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        if (restart) restarts_sent++;
    endtask

    // Output side: random stalls, plus one long hold-off once traffic is flowing.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = 299;
            i_out_stall <= 1'b1;
        end else if (idle_length(stall_pct) > 0) begin
            hold_left = idle_length(100) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (o_overflow) overflows_seen++;
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected result median %0d overflow %0b",
                         $time, o_median, o_overflow);
                errors++;
            end else begin
                want = pending_medians.pop_front();
                if (o_median !== want.median) begin
                    $display("%0t: median mismatch, expected %0d, actual %0d",
                             $time, want.median, o_median);
                    errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch, expected %0b, actual %0b",
                             $time, want.overflow, o_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int unsigned seq_len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k])
            send_sample(script[k].restart, script[k].value, script[k].chk, script[k].median);

        // Fill both halves to capacity, then push samples at the full halves.
        send_sample(1'b1, random_sample(), CHK_PREDICT, '0);
        for (int k = 1; k < 2 * rmth_pkg::HEAP_DEPTH - 1; k++) begin
            if (k % 100 == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            send_sample(1'b0, random_sample(), CHK_PREDICT, '0);
        end
        for (int k = 0; k < 12; k++)
            send_sample(1'b0, (k % 2 == 0) ? S_MIN : S_MAX, CHK_PREDICT, '0);
        repeat (8) send_sample(1'b0, random_sample(), CHK_PREDICT, '0);

        // Short sequences, each opened by a restart.
        while (samples_sent < SAMPLE_GOAL) begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
            seq_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 40);
            for (int k = 0; k < seq_len; k++)
                send_sample(k == 0, random_sample(), CHK_PREDICT, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d samples sent with %0d restarts; %0d results checked, %0d of them dropped samples",
                 samples_sent, restarts_sent, results_seen, overflows_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* running_median_two_heaps_unit.f */
sv/rmth_pkg.sv
sv/rmth_cell.sv
sv/rmth_chain.sv
sv/running_median_two_heaps_unit.sv
verif/running_median_two_heaps_unit_tb.sv
